// ----- hdl/ultrasonic_echo_ranger_macros.svh -----
// assertion shorthands for the echo ranger, clocked on clk, quiet in reset
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// same-cycle implication
`define UER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/uer_pkg.sv -----
package uer_pkg;

    // field and register widths
    localparam int CNT_W   = 32;
    localparam int TRIG_W  = 20;
    localparam int MINP_W  = 16;
    localparam int FREQ_W  = 30;
    localparam int DIST_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_FREQ    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USE_SYNC      = 3'd4;

    // register reset values
    localparam logic [CNT_W-1:0]  RST_SAMPLE_PERIOD = 32'd100000;
    localparam logic [TRIG_W-1:0] RST_TRIGGER_TICKS = 20'd1000;
    localparam logic [MINP_W-1:0] RST_MIN_PULSE     = 16'd10;
    localparam logic [FREQ_W-1:0] RST_TIMER_FREQ    = 30'd1000000;

    // half the speed of sound in mm per second
    localparam int SCALE_W = 18;
    localparam logic [SCALE_W-1:0] DIST_SCALE = 18'd171000;

    // divider widths: dividend is scale times width, quotient is 16 bits
    localparam int PROD_W = SCALE_W + CNT_W;
    localparam int QUO_W  = DIST_W;
    localparam int DIVR_W = FREQ_W + QUO_W;
    localparam int STEP_W = $clog2(QUO_W);

    // tick queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [CNT_W-1:0]  sample_period_ticks;
        logic [TRIG_W-1:0] trigger_ticks;
        logic [MINP_W-1:0] min_pulse_ticks;
        logic [FREQ_W-1:0] timer_freq_hz;
        logic              use_sync;
    } cfg_t;

    // one classified tick
    typedef struct packed {
        logic             trigger;
        logic             reading;
        logic             timeout;
        logic [CNT_W-1:0] width;
    } tick_t;

    typedef struct packed {
        logic busy;
    } back_stat_t;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_TRIG_RISE = 7'b0000010,
        PH_TRIG_FALL = 7'b0000100,
        PH_TRIG_DONE = 7'b0001000,
        PH_WAIT_RISE = 7'b0010000,
        PH_WAIT_FALL = 7'b0100000,
        PH_HOLD      = 7'b1000000
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_PUSH  = 5'b01000,
        ST_EMIT  = 5'b10000
    } back_st_t;

endpackage

// ----- hdl/uer_front.sv -----
module uer_front
    import uer_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  accept,
    input  logic  echo_level,
    input  logic  sync_pulse,
    output tick_t item
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  width_reg;
    logic [CNT_W-1:0]  width_next;
    logic              prev_echo_reg;

    logic              trig;
    logic              reading;
    logic              timeout;

    // one timer tick of the ranging sequence
    always_comb
    begin
        logic              rise;
        logic              fall;
        logic              valid_fall;
        logic [CNT_W:0]    diff_trig;
        logic [CNT_W+1:0]  elapsed;
        logic [CNT_W+1:0]  diff_wait;
        logic [TRIG_W-1:0] trig_eff;

        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        width_next = width_reg;
        trig       = 1'b0;
        reading    = 1'b0;
        timeout    = 1'b0;
        rise       = echo_level & ~prev_echo_reg;
        fall       = ~echo_level & prev_echo_reg;
        valid_fall = 1'b0;
        trig_eff   = (cfg.trigger_ticks == '0) ? TRIG_W'(1) : cfg.trigger_ticks;
        diff_trig  = '0;
        elapsed    = '0;
        diff_wait  = '0;

        // hold off until the sample period is used up
        if (phase_next == PH_HOLD)
        begin
            if (cnt_next == '0)
                phase_next = PH_IDLE;
            else
                cnt_next = cnt_next - CNT_W'(1);
        end

        // start a sample
        if (phase_next == PH_IDLE && (!cfg.use_sync || sync_pulse))
        begin
            phase_next = PH_TRIG_RISE;
            cnt_next   = '0;
            width_next = '0;
        end

        // echo edges while armed
        if (phase_next == PH_TRIG_RISE || phase_next == PH_WAIT_RISE)
        begin
            if (rise)
            begin
                width_next = '0;
                phase_next = (phase_next == PH_TRIG_RISE) ? PH_TRIG_FALL : PH_WAIT_FALL;
            end
        end
        else if (phase_next == PH_TRIG_FALL || phase_next == PH_WAIT_FALL)
        begin
            if (width_next != '1)
                width_next = width_next + CNT_W'(1);
            valid_fall = fall && (width_next >= CNT_W'(cfg.min_pulse_ticks));
        end

        // trigger window and echo timeout window
        if (phase_next == PH_TRIG_RISE || phase_next == PH_TRIG_FALL ||
            phase_next == PH_TRIG_DONE)
        begin
            trig = 1'b1;
            if (valid_fall)
            begin
                reading    = 1'b1;
                phase_next = PH_TRIG_DONE;
            end
            cnt_next = cnt_next + CNT_W'(1);
            if (cnt_next >= CNT_W'(cfg.trigger_ticks))
            begin
                if (phase_next == PH_TRIG_DONE)
                begin
                    diff_trig  = {1'b0, cfg.sample_period_ticks} - {1'b0, cnt_next};
                    cnt_next   = diff_trig[CNT_W] ? '0 : diff_trig[CNT_W-1:0];
                    phase_next = PH_HOLD;
                end
                else
                begin
                    phase_next = (phase_next == PH_TRIG_RISE) ? PH_WAIT_RISE : PH_WAIT_FALL;
                    cnt_next   = '0;
                end
            end
        end
        else if (phase_next == PH_WAIT_RISE || phase_next == PH_WAIT_FALL)
        begin
            if (valid_fall)
            begin
                reading    = 1'b1;
                elapsed    = (CNT_W+2)'(trig_eff) + (CNT_W+2)'(cnt_next) + (CNT_W+2)'(1);
                diff_wait  = (CNT_W+2)'(cfg.sample_period_ticks) - elapsed;
                cnt_next   = diff_wait[CNT_W+1] ? '0 : diff_wait[CNT_W-1:0];
                phase_next = PH_HOLD;
            end
            else
            begin
                cnt_next = cnt_next + CNT_W'(1);
                if (cnt_next >= cfg.sample_period_ticks)
                begin
                    timeout    = 1'b1;
                    phase_next = PH_HOLD;
                    cnt_next   = '0;
                end
            end
        end
    end

    // tick state, advanced once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            width_reg     <= '0;
            prev_echo_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            width_reg     <= width_next;
            prev_echo_reg <= echo_level;
        end
    end

    assign item.trigger = trig;
    assign item.reading = reading;
    assign item.timeout = timeout;
    assign item.width   = width_next;

endmodule

// ----- hdl/uer_queue.sv -----
module uer_queue
    import uer_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  tick_t push_item,
    input  logic  pop,
    output tick_t head,
    output logic  empty,
    output logic  full
);

    tick_t           entry_reg [Q_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QP_W:0]   count_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QP_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QP_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QP_W+1)'(1);
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QP_W+1)'(Q_DEPTH));

endmodule

// ----- hdl/uer_back.sv -----
module uer_back
    import uer_pkg::*;
#(
    parameter int FILTER_DEPTH = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [FREQ_W-1:0] timer_freq_hz,
    input  tick_t             head,
    input  logic              q_empty,
    output logic              pop,
    output back_stat_t        stat,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // bit 0 trigger_out, 16:1 avg_distance_mm, 17 new_reading, 18 timed_out, 23:19 zero
    output logic [OUT_W-1:0]  m_axis_tdata
);

    localparam int IW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int SW = DIST_W + $clog2(FILTER_DEPTH);

    // average by reciprocal multiply, exact for every sum below 2^SW
    localparam int AVG_SH = SW + $clog2(FILTER_DEPTH);
    localparam logic [63:0] AVG_RECIP_W = ((64'd1 << AVG_SH) + 64'(FILTER_DEPTH) - 64'd1)
                                          / 64'(FILTER_DEPTH);
    localparam logic [SW:0] AVG_RECIP = AVG_RECIP_W[SW:0];
    localparam int AP_W = 2 * SW + 1;

    back_st_t           st_reg;
    back_st_t           st_next;

    // ring store and running sum
    logic [DIST_W-1:0]  ring_mem [FILTER_DEPTH];
    logic [DIST_W-1:0]  rd_data_reg;
    logic [SW-1:0]      sum_reg;
    logic [SW-1:0]      sum_next;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      idx_next;
    logic               wrap_reg;
    logic               wrap_next;
    logic [DIST_W-1:0]  avg_reg;
    logic [DIST_W-1:0]  avg_next;

    // restoring divider for the distance
    logic [PROD_W-1:0]  rem_reg;
    logic [DIVR_W-1:0]  div_reg;
    logic [QUO_W-1:0]   q_reg;
    logic [STEP_W-1:0]  step_reg;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_trig_reg;
    logic [DIST_W-1:0]  out_avg_reg;
    logic               out_nr_reg;
    logic               out_to_reg;

    logic [FREQ_W-1:0]  freq_eff;
    logic [PROD_W-1:0]  product;
    logic               sat;
    logic               ge;
    logic [PROD_W-1:0]  rem_sub;
    logic [QUO_W-1:0]   q_next;
    logic [DIST_W-1:0]  old_val;
    logic [SW-1:0]      sum_new;
    logic [AP_W-1:0]    avg_prod;
    logic [DIST_W-1:0]  avg_calc;
    logic               out_free;
    logic               out_load;
    logic               out_nr;

    // arithmetic
    assign freq_eff = (timer_freq_hz == '0) ? FREQ_W'(1) : timer_freq_hz;
    assign product  = PROD_W'(DIST_SCALE) * PROD_W'(head.width);
    assign sat      = rem_reg >= (PROD_W'(freq_eff) << QUO_W);
    assign ge       = rem_reg >= PROD_W'(div_reg);
    assign rem_sub  = rem_reg - PROD_W'(div_reg);
    assign q_next   = {q_reg[QUO_W-2:0], ge};
    assign old_val  = wrap_reg ? rd_data_reg : '0;
    assign sum_new  = sum_reg - SW'(old_val) + SW'(q_reg);
    assign avg_prod = AP_W'(sum_reg) * AP_W'(AVG_RECIP);
    assign avg_calc = avg_prod[AVG_SH +: DIST_W];
    assign out_free = !out_valid_reg || m_axis_tready;

    // sequencing of one reading: scale, divide, push, average, emit; plain ticks emit from idle
    always_comb
    begin
        st_next        = st_reg;
        pop            = 1'b0;
        out_load       = 1'b0;
        out_nr         = 1'b0;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        wrap_next      = wrap_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head.reading)
                        st_next = ST_CHECK;
                    else if (out_free)
                    begin
                        out_load = 1'b1;
                        pop      = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                st_next = sat ? ST_PUSH : ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                    st_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                sum_next = sum_new;
                if (idx_reg == IW'(FILTER_DEPTH - 1))
                begin
                    idx_next  = '0;
                    wrap_next = 1'b1;
                end
                else
                    idx_next = idx_reg + IW'(1);
                st_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                avg_next = avg_calc;
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_nr   = 1'b1;
                    pop      = 1'b1;
                    st_next  = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
        if (out_load)
            out_valid_next = 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            sum_reg       <= '0;
            idx_reg       <= '0;
            wrap_reg      <= 1'b0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            wrap_reg      <= wrap_next;
            avg_reg       <= avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and ring store
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
            begin
                rem_reg     <= product;
                rd_data_reg <= ring_mem[idx_reg];
            end
            ST_CHECK:
            begin
                if (sat)
                    q_reg <= '1;
                else
                begin
                    div_reg  <= DIVR_W'(freq_eff) << (QUO_W - 1);
                    step_reg <= STEP_W'(QUO_W - 1);
                end
            end
            ST_DIV:
            begin
                if (ge)
                    rem_reg <= rem_sub;
                div_reg  <= div_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
                q_reg    <= q_next;
            end
            ST_PUSH:
            begin
                ring_mem[idx_reg] <= q_reg;
            end
            ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_trig_reg <= head.trigger;
            out_avg_reg  <= avg_next;
            out_nr_reg   <= out_nr;
            out_to_reg   <= head.timeout;
        end
    end

    assign stat.busy     = (st_reg != ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_W - DIST_W - 3)'(0), out_to_reg, out_nr_reg, out_avg_reg,
                            out_trig_reg};

endmodule

// ----- hdl/ultrasonic_echo_ranger.sv -----
// channel  | group      | beat carries
// ---------+------------+-----------------------------------------------------------
// ticks in | s_axis_*   | tdata: 0 echo_level, 1 sync_pulse
// results  | m_axis_*   | tdata: 0 trigger_out, 16:1 avg_distance_mm, 17 new_reading,
//          |            |        18 timed_out
// config   | cfg_*      | cfg_index register index, cfg_data value, always ready
//
// one tick per cycle while the queue has room; plain beats pass queue and output register
// a tick that completes a reading holds the back end through one multiply, 16 quotient
// steps (none when the distance saturates), ring push and the reciprocal average
// a four-beat tick queue absorbs part of that; s_axis_tready drops when it is full
// reset clears the control state at once; the ring store needs no clearing pass
// a stall on m_axis fills the queue and then stalls s_axis
`include "ultrasonic_echo_ranger_macros.svh"

module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int FILTER_DEPTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // bit 0 echo_level, 1 sync_pulse, 7:2 zero
    input  logic [IN_W-1:0]       s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // bit 0 trigger_out, 16:1 avg_distance_mm, 17 new_reading, 18 timed_out, 23:19 zero
    output logic [OUT_W-1:0]      m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       accept;
    tick_t      front_item;
    tick_t      q_head;
    logic       q_empty;
    logic       q_full;
    logic       q_pop;
    back_stat_t back_stat;
    logic       beat_trig;
    logic       beat_nr;
    logic       beat_to;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_period_ticks <= RST_SAMPLE_PERIOD;
            cfg_reg.trigger_ticks       <= RST_TRIGGER_TICKS;
            cfg_reg.min_pulse_ticks     <= RST_MIN_PULSE;
            cfg_reg.timer_freq_hz       <= RST_TIMER_FREQ;
            cfg_reg.use_sync            <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SAMPLE_PERIOD: cfg_reg.sample_period_ticks <= cfg_data[CNT_W-1:0];
                REG_TRIGGER_TICKS: cfg_reg.trigger_ticks       <= cfg_data[TRIG_W-1:0];
                REG_MIN_PULSE:     cfg_reg.min_pulse_ticks     <= cfg_data[MINP_W-1:0];
                REG_TIMER_FREQ:    cfg_reg.timer_freq_hz       <= cfg_data[FREQ_W-1:0];
                REG_USE_SYNC:      cfg_reg.use_sync            <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // tick classification
    uer_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .echo_level (s_axis_tdata[0]),
        .sync_pulse (s_axis_tdata[1]),
        .item       (front_item)
    );

    // decoupling queue
    uer_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // distance, filter and result beats
    uer_back #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .timer_freq_hz (cfg_reg.timer_freq_hz),
        .head          (q_head),
        .q_empty       (q_empty),
        .pop           (q_pop),
        .stat          (back_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // result beat flags
    assign beat_trig = m_axis_tdata[0];
    assign beat_nr   = m_axis_tdata[17];
    assign beat_to   = m_axis_tdata[18];

    // a reading and a timeout never share a beat
    `UER_ASSERT_NOW(a_read_or_timeout, m_axis_tvalid, !(beat_nr && beat_to), "read and timeout")

    // timeouts only happen after the trigger has ended
    `UER_ASSERT_NOW(a_timeout_no_trig, m_axis_tvalid && beat_to, !beat_trig, "timeout in trigger")

    // the back end only works on a queued reading tick
    `UER_ASSERT_NOW(a_busy_has_reading, back_stat.busy, !q_empty && q_head.reading, "busy, no read")

    // an accepted tick is held in the queue on the next cycle
    `UER_ASSERT_NEXT(a_accept_queued, accept, !q_empty, "accepted tick lost from queue")

endmodule
